// ===== sv/crce_pkg.sv =====
package crce_pkg;

  // Command codes carried in the cmd field of an input word.
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_EVAL   = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  // Status codes reported with every result word.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FEW   = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_ZERO  = 2'd3;

  // Read phases that fetch one segment's knots from the two tables.
  localparam logic [1:0] RD_A = 2'd0;
  localparam logic [1:0] RD_B = 2'd1;
  localparam logic [1:0] RD_C = 2'd2;
  localparam logic [1:0] RD_D = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] y_out;
    logic [1:0]         status;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       latch;
    logic       clear;
    logic       append;
    logic       scan_issue;
    logic       rd_en;
    logic [1:0] rd_phase;
    logic       div_init;
    logic       div_step;
    logic       coef_load;
    logic       mul;
    logic       add;
    logic       finish;
    logic       use_y;
    logic [1:0] status;
  } ctrl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic [1:0] cmd;
    logic       full;
    logic       few;
    logic       no_scan;
    logic       scan_last;
    logic       dx_zero;
    logic       div_last;
    logic       horner_last;
    logic       out_busy;
  } dp_stat_t;

endpackage

// ===== sv/crce_ram.sv =====
module crce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/crce_dp.sv =====
module crce_dp #(
  parameter int MAX_POINTS = 64,
  parameter int FRAC_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  crce_pkg::in_word_t  in_data,
  input  logic                out_ready,
  output logic                out_valid,
  output crce_pkg::out_word_t out_data,
  input  crce_pkg::ctrl_cmd_t cmd,
  output crce_pkg::dp_stat_t  stat
);

  localparam int AIW  = $clog2(MAX_POINTS);
  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int NW   = 32 + FRAC_BITS;
  localparam int DCW  = $clog2(NW);
  localparam int TW   = FRAC_BITS + 6;
  localparam int AW   = 36;
  localparam int PW   = AW + TW;
  localparam int SW   = PW - FRAC_BITS + 1;

  localparam logic [TW-1:0]        T_LIM  = TW'(64'd16 << FRAC_BITS);
  localparam logic signed [SW-1:0] ACC_HI = SW'(64'sd1 <<< 34);
  localparam logic signed [SW-1:0] ACC_LO = -ACC_HI;
  localparam logic signed [AW-1:0] Y_HI   = AW'(64'sh7FFF_FFFF);
  localparam logic signed [AW-1:0] Y_LO   = -Y_HI - AW'(64'sd1);

  logic [1:0]         cmd_q;
  logic signed [31:0] xq;
  logic signed [31:0] yq;
  logic [CNTW-1:0]    count;
  logic [AIW-1:0]     seg;
  logic [AIW-1:0]     j;
  logic [AIW-1:0]     j_d;
  logic               cmp_v;
  logic               rd_v_d;
  logic [1:0]         rd_ph_d;
  logic signed [31:0] x0, x1, y0, y1, y2, y3;
  logic [31:0]        rem;
  logic [NW-1:0]      quo;
  logic [31:0]        dmag;
  logic               neg_q;
  logic [DCW-1:0]     dcnt;
  logic signed [TW-1:0] t;
  logic signed [AW-1:0] cb, cc, cd, acc;
  logic signed [PW-1:0] prod;
  logic [1:0]         k;

  logic [31:0]        x_rdata, y_rdata;
  logic [AIW-1:0]     x_raddr, y_raddr;
  logic [CNTW-1:0]    seg_p1, seg_p2;
  logic [AIW-1:0]     y0a, y3a;
  logic signed [32:0] dx, diff, dx_abs, diff_abs;
  logic [32:0]        r2, r2_sub;
  logic               ge;
  logic [TW-1:0]      tmag;
  logic signed [AW-1:0] e0, e1, e2, e3, ca;
  logic signed [AW-1:0] nx;
  logic signed [SW-1:0] sum;
  logic signed [AW-1:0] yh, ysat;

  // Knot tables.
  crce_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_xram (
    .clk(clk), .we(cmd.append), .waddr(count[AIW-1:0]), .wdata(xq),
    .raddr(x_raddr), .rdata(x_rdata)
  );

  crce_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_yram (
    .clk(clk), .we(cmd.append), .waddr(count[AIW-1:0]), .wdata(yq),
    .raddr(y_raddr), .rdata(y_rdata)
  );

  // Neighbor addresses, with the end knots standing in for missing ones.
  always_comb begin
    seg_p1 = CNTW'(seg) + CNTW'(1);
    seg_p2 = CNTW'(seg) + CNTW'(2);
    y0a    = (seg == '0) ? seg : seg - AIW'(1);
    y3a    = (seg_p2 >= count) ? seg_p1[AIW-1:0] : seg_p2[AIW-1:0];
    x_raddr = seg;
    y_raddr = y0a;
    if (cmd.scan_issue) begin
      x_raddr = j;
    end else begin
      unique case (cmd.rd_phase)
        crce_pkg::RD_A: begin x_raddr = seg;              y_raddr = y0a; end
        crce_pkg::RD_B: begin x_raddr = seg_p1[AIW-1:0];  y_raddr = seg; end
        crce_pkg::RD_C: begin x_raddr = seg_p1[AIW-1:0];  y_raddr = seg_p1[AIW-1:0]; end
        crce_pkg::RD_D: begin x_raddr = seg_p1[AIW-1:0];  y_raddr = y3a; end
        default:        begin x_raddr = seg;              y_raddr = y0a; end
      endcase
    end
  end

  // Division and coefficient arithmetic.
  always_comb begin
    dx       = {x1[31], x1} - {x0[31], x0};
    diff     = {xq[31], xq} - {x0[31], x0};
    dx_abs   = dx[32] ? -dx : dx;
    diff_abs = diff[32] ? -diff : diff;
    r2       = {rem, quo[NW-1]};
    r2_sub   = r2 - {1'b0, dmag};
    ge       = (r2 >= {1'b0, dmag});
    tmag     = (quo > {{(NW-TW){1'b0}}, T_LIM}) ? T_LIM : quo[TW-1:0];
    e0 = AW'(y0);
    e1 = AW'(y1);
    e2 = AW'(y2);
    e3 = AW'(y3);
    ca = -e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3;
    unique case (k)
      2'd0:    nx = cb;
      2'd1:    nx = cc;
      default: nx = cd;
    endcase
    sum  = SW'(prod >>> FRAC_BITS) + SW'(nx);
    yh   = acc >>> 1;
    ysat = (yh > Y_HI) ? Y_HI : ((yh < Y_LO) ? Y_LO : yh);
  end

  // Item registers, table count and knot search.
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      cmp_v  <= 1'b0;
      rd_v_d <= 1'b0;
    end else begin
      cmp_v   <= cmd.scan_issue;
      rd_v_d  <= cmd.rd_en;
      rd_ph_d <= cmd.rd_phase;
      j_d     <= j;
      if (cmd.latch) begin
        cmd_q <= in_data.cmd;
        xq    <= in_data.x_value;
        yq    <= in_data.y_value;
        seg   <= '0;
        j     <= AIW'(1);
      end
      if (cmd.clear) begin
        count <= '0;
      end else if (cmd.append) begin
        count <= count + CNTW'(1);
      end
      if (cmd.scan_issue) begin
        j <= j + AIW'(1);
      end
      if (cmp_v && ($signed(x_rdata) <= xq)) begin
        seg <= j_d;
      end
    end
  end

  // Capture of the segment's knots in the cycle after each read.
  always_ff @(posedge clk) begin
    if (rd_v_d) begin
      unique case (rd_ph_d)
        crce_pkg::RD_A: begin x0 <= x_rdata; y0 <= y_rdata; end
        crce_pkg::RD_B: begin x1 <= x_rdata; y1 <= y_rdata; end
        crce_pkg::RD_C: y2 <= y_rdata;
        crce_pkg::RD_D: y3 <= y_rdata;
        default: ;
      endcase
    end
  end

  // Restoring divider for t, then the Horner steps.
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dmag  <= dx_abs[31:0];
      quo   <= {diff_abs[31:0], {FRAC_BITS{1'b0}}};
      rem   <= '0;
      dcnt  <= '0;
      neg_q <= diff[32] ^ dx[32];
    end else if (cmd.div_step) begin
      rem  <= ge ? r2_sub[31:0] : r2[31:0];
      quo  <= {quo[NW-2:0], ge};
      dcnt <= dcnt + DCW'(1);
    end
    if (cmd.coef_load) begin
      t   <= neg_q ? -$signed(tmag) : $signed(tmag);
      acc <= ca;
      cb  <= (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
      cc  <= e2 - e0;
      cd  <= e1 <<< 1;
      k   <= 2'd0;
    end
    if (cmd.mul) begin
      prod <= acc * t;
    end
    if (cmd.add) begin
      acc <= (sum > ACC_HI) ? AW'(ACC_HI) : ((sum < ACC_LO) ? AW'(ACC_LO) : AW'(sum));
      k   <= k + 2'd1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.finish) begin
      out_data.y_out  <= cmd.use_y ? ysat[31:0] : 32'sd0;
      out_data.status <= cmd.status;
    end
  end

  always_comb begin
    stat.cmd         = cmd_q;
    stat.full        = (count == CNTW'(MAX_POINTS));
    stat.few         = (count < CNTW'(2));
    stat.no_scan     = (count < CNTW'(3));
    stat.scan_last   = (CNTW'(j) == count - CNTW'(2));
    stat.dx_zero     = (x1 == x0);
    stat.div_last    = (dcnt == DCW'(NW - 1));
    stat.horner_last = (k == 2'd2);
    stat.out_busy    = out_valid & ~out_ready;
  end

endmodule

// ===== sv/crce_ctrl.sv =====
module crce_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  crce_pkg::dp_stat_t  stat,
  output crce_pkg::ctrl_cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_SWAIT  = 4'd3;
  localparam logic [3:0] S_RA     = 4'd4;
  localparam logic [3:0] S_RB     = 4'd5;
  localparam logic [3:0] S_RC     = 4'd6;
  localparam logic [3:0] S_RD     = 4'd7;
  localparam logic [3:0] S_RE     = 4'd8;
  localparam logic [3:0] S_DIV    = 4'd9;
  localparam logic [3:0] S_COEF   = 4'd10;
  localparam logic [3:0] S_MUL    = 4'd11;
  localparam logic [3:0] S_ADD    = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0] state, state_next;
  logic [1:0] code, code_next;
  logic       use_y, use_y_next;

  // Sequencing of one word.
  always_comb begin
    state_next = state;
    code_next  = code;
    use_y_next = use_y;
    cmd        = '0;
    cmd.rd_phase = crce_pkg::RD_A;
    cmd.use_y  = use_y;
    cmd.status = code;
    // No word is taken while reset is held.
    in_ready   = (state == S_IDLE) && !rst;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        code_next  = crce_pkg::STAT_OK;
        use_y_next = 1'b0;
        state_next = S_DONE;
        unique case (stat.cmd)
          crce_pkg::CMD_CLEAR: cmd.clear = 1'b1;
          crce_pkg::CMD_APPEND: begin
            if (stat.full) begin
              code_next = crce_pkg::STAT_FULL;
            end else begin
              cmd.append = 1'b1;
            end
          end
          crce_pkg::CMD_EVAL: begin
            if (stat.few) begin
              code_next = crce_pkg::STAT_FEW;
            end else if (stat.no_scan) begin
              state_next = S_SWAIT;
            end else begin
              state_next = S_SCAN;
            end
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (stat.scan_last) begin
          state_next = S_SWAIT;
        end
      end
      S_SWAIT: state_next = S_RA;
      S_RA: begin
        cmd.rd_en = 1'b1;
        cmd.rd_phase = crce_pkg::RD_A;
        state_next = S_RB;
      end
      S_RB: begin
        cmd.rd_en = 1'b1;
        cmd.rd_phase = crce_pkg::RD_B;
        state_next = S_RC;
      end
      S_RC: begin
        cmd.rd_en = 1'b1;
        cmd.rd_phase = crce_pkg::RD_C;
        state_next = S_RD;
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_phase = crce_pkg::RD_D;
        state_next = S_RE;
      end
      S_RE: begin
        if (stat.dx_zero) begin
          code_next  = crce_pkg::STAT_ZERO;
          state_next = S_DONE;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_COEF;
        end
      end
      S_COEF: begin
        cmd.coef_load = 1'b1;
        state_next    = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add = 1'b1;
        if (stat.horner_last) begin
          use_y_next = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_MUL;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= crce_pkg::STAT_OK;
      use_y <= 1'b0;
    end else begin
      state <= state_next;
      code  <= code_next;
      use_y <= use_y_next;
    end
  end

endmodule

// ===== sv/catmull_rom_curve_evaluator.sv =====
// Catmull-Rom curve evaluator. Words carry a command: clear the knot table, append a
// Q16.16 (x, y) knot, evaluate the curve at x, or do nothing; every word returns exactly
// one result word with y_out and a status. The block handles one word at a time. An
// evaluate scans the x table through its single read port, does four knot reads, runs a
// restoring divider that produces one quotient bit per cycle for t, and ends with three
// Horner multiply-add steps.
// A new word is taken while the previous result still waits in the output register.
module catmull_rom_curve_evaluator #(
  parameter int MAX_POINTS = 64,
  parameter int FRAC_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  crce_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output crce_pkg::out_word_t out_data
);

  crce_pkg::ctrl_cmd_t cmd;
  crce_pkg::dp_stat_t  stat;

  crce_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .stat(stat), .cmd(cmd)
  );

  crce_dp #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .in_data(in_data), .out_ready(out_ready),
    .out_valid(out_valid), .out_data(out_data), .cmd(cmd), .stat(stat)
  );

endmodule

// ===== sv/crce_checker.sv =====
module crce_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input crce_pkg::in_word_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input crce_pkg::out_word_t out_data
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // Only one word is in flight: ready drops right after an accept.
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while busy");

  // Any failing status comes with a zero value.
  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != crce_pkg::STAT_OK |-> out_data.y_out == 32'sd0)
    else $error("nonzero value with failing status");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind catmull_rom_curve_evaluator crce_checker u_chk (.*);

// ===== sim/catmull_rom_curve_evaluator_test.sv =====
module catmull_rom_curve_evaluator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KNOT_DEPTH = 64;
  localparam int FRAC = 16;
  localparam longint ACC_BOUND = 64'sd1 << 34;
  localparam longint T_BOUND = 64'sd16 << FRAC;
  localparam int STALL_LIMIT = 20000;

  // Curve predictor and queue of expected result words.
  class curve_scoreboard;
    logic signed [31:0] knot_xs[KNOT_DEPTH];
    logic signed [31:0] knot_ys[KNOT_DEPTH];
    int knots;
    crce_pkg::out_word_t pending[$];
    int errors;

    function new();
      knots = 0;
      errors = 0;
    endfunction

    function longint bound(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // Floor of acc * t / 2^FRAC plus the next coefficient, saturated.
    function longint horner(longint acc, longint t, longint nxt);
      longint p;
      p = acc * t;
      p = p >>> FRAC;
      return bound(p + nxt, -ACC_BOUND, ACC_BOUND);
    endfunction

    function crce_pkg::out_word_t evaluate(longint xq);
      crce_pkg::out_word_t r;
      int seg;
      longint x0, dx, y0, y1, y2, y3, t, acc, half;
      r = '0;
      if (knots < 2) begin
        r.status = crce_pkg::STAT_FEW;
        return r;
      end
      seg = 0;
      for (int j = 1; j + 1 < knots; j++)
        if (longint'(knot_xs[j]) <= xq) seg = j;
      x0 = knot_xs[seg];
      dx = longint'(knot_xs[seg + 1]) - x0;
      if (dx == 0) begin
        r.status = crce_pkg::STAT_ZERO;
        return r;
      end
      y1 = knot_ys[seg];
      y2 = knot_ys[seg + 1];
      y0 = (seg == 0) ? y1 : longint'(knot_ys[seg - 1]);
      y3 = (seg + 2 >= knots) ? y2 : longint'(knot_ys[seg + 2]);
      t = bound(((xq - x0) * (64'sd1 << FRAC)) / dx, -T_BOUND, T_BOUND);
      acc = -y0 + 3 * y1 - 3 * y2 + y3;
      acc = horner(acc, t, 2 * y0 - 5 * y1 + 4 * y2 - y3);
      acc = horner(acc, t, y2 - y0);
      acc = horner(acc, t, 2 * y1);
      half = acc >>> 1;
      r.y_out = 32'(bound(half, -64'sd2147483648, 64'sd2147483647));
      r.status = crce_pkg::STAT_OK;
      return r;
    endfunction

    function void note_input(crce_pkg::in_word_t w);
      crce_pkg::out_word_t r;
      r = '0;
      case (w.cmd)
        crce_pkg::CMD_CLEAR: knots = 0;
        crce_pkg::CMD_APPEND: begin
          if (knots >= KNOT_DEPTH) r.status = crce_pkg::STAT_FULL;
          else begin
            knot_xs[knots] = w.x_value;
            knot_ys[knots] = w.y_value;
            knots++;
          end
        end
        crce_pkg::CMD_EVAL: r = evaluate(longint'(w.x_value));
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(crce_pkg::out_word_t got);
      crce_pkg::out_word_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result y_out=%0d status=%0d", $time, got.y_out,
                 got.status);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.y_out !== want.y_out) begin
        $display("%0t: y_out expected %0d actual %0d", $time, want.y_out, got.y_out);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  crce_pkg::in_word_t in_data;
  crce_pkg::out_word_t out_data;
  curve_scoreboard board;
  bit calm;
  int idle_cycles;

  catmull_rom_curve_evaluator DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver side: check accepted results and stall in random bursts.
  initial begin
    int hold;
    out_ready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) board.check_result(out_data);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 11) - 1;
        out_ready <= 1'b0;
      end else out_ready <= 1'b1;
    end
  end

  // Watchdog: cycles in a row with no word accepted on either side.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Present one word, hold it until accepted, then maybe pause in a burst.
  task automatic send_word(logic [1:0] cmd, logic [31:0] xv, logic [31:0] yv);
    crce_pkg::in_word_t w;
    w.cmd = cmd;
    w.x_value = xv;
    w.y_value = yv;
    in_data <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    board.note_input(w);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 2) - 1;
      default: return $urandom();
    endcase
  endfunction

  // Build a table of n knots in non-decreasing x, then evaluate many points on it.
  task automatic curve_set(int n, int evals);
    int xs;
    int step;
    step = $urandom_range(1, 8) << $urandom_range(8, 18);
    xs = -(n * step) / 2;
    send_word(crce_pkg::CMD_CLEAR, $urandom(), $urandom());
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 15) == 0) send_word(crce_pkg::CMD_APPEND, xs, rand_word());
      else send_word(crce_pkg::CMD_APPEND, xs,
                     $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000);
      if ($urandom_range(0, 20) != 0) xs += $urandom_range(1, step);
    end
    for (int k = 0; k < evals; k++) begin
      case ($urandom_range(0, 9))
        0: send_word(2'(rand_word()), rand_word(), rand_word());
        1: send_word(crce_pkg::CMD_EVAL, rand_word(), $urandom());
        default: send_word(crce_pkg::CMD_EVAL, xs - $urandom_range(0, n * step + step),
                           $urandom());
      endcase
    end
  endtask

  initial begin
    int sent;
    board = new();
    calm = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty and one-point tables, no-op, zero width, extremes.
    send_word(crce_pkg::CMD_EVAL, 32'd0, 32'd0);
    send_word(crce_pkg::CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(crce_pkg::CMD_APPEND, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(crce_pkg::CMD_EVAL, 32'd5, 32'd0);
    send_word(crce_pkg::CMD_APPEND, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(crce_pkg::CMD_EVAL, 32'd0, 32'd0);
    send_word(crce_pkg::CMD_EVAL, 32'h8000_0000, 32'd0);
    send_word(crce_pkg::CMD_EVAL, 32'h7FFF_FFFF, 32'd0);
    send_word(crce_pkg::CMD_CLEAR, 32'd0, 32'd0);
    send_word(crce_pkg::CMD_APPEND, 32'h0001_0000, 32'h0001_0000);
    send_word(crce_pkg::CMD_APPEND, 32'h0001_0000, 32'h0002_0000);
    send_word(crce_pkg::CMD_EVAL, 32'h0001_0000, 32'd0);
    send_word(crce_pkg::CMD_APPEND, 32'h0000_0000, 32'h7FFF_FFFF);
    send_word(crce_pkg::CMD_EVAL, 32'h0001_8000, 32'd0);
    send_word(crce_pkg::CMD_EVAL, 32'hFFF0_0000, 32'd0);
    drain();

    // Fill the table to the brim and overflow it.
    send_word(crce_pkg::CMD_CLEAR, 32'd0, 32'd0);
    for (int k = 0; k < KNOT_DEPTH + 2; k++)
      send_word(crce_pkg::CMD_APPEND, k << 16, $urandom());
    send_word(crce_pkg::CMD_EVAL, 32'h0010_8000, 32'd0);
    send_word(crce_pkg::CMD_EVAL, 32'h7FFF_FFFF, 32'd0);

    // Random curves, mostly small tables.
    sent = 0;
    while (sent < 650) begin
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(2, KNOT_DEPTH)
                                      : $urandom_range(2, 8);
      curve_set(n, 12);
      sent += n + 13;
    end

    // Final stretch with no idling on either side.
    calm = 1'b1;
    curve_set(5, 30);
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
